// File: rtl/lcar_pkg.sv
`timescale 1ns / 1ps

package lcar_pkg;

   // Fixed field widths
   localparam int CFG_W    = 24;
   localparam int RAW_W    = 24;
   localparam int GLITCH_W = 5;
   localparam int WEIGHT_W = 33;
   localparam int CSR_IDX_W = 4;

   // Defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEF     = 24;
   localparam int TARE_SAMPLES_DEF    = 32;
   localparam int MEASURE_SAMPLES_DEF = 4;

   // Fixed-point layout: means carry 5 fraction bits, the weight 8
   localparam int MEAN_FRAC    = 5;
   localparam int WEIGHT_SHIFT = 3;

   localparam logic [CFG_W-1:0]    TIMEOUT_RESET = CFG_W'(1000000);
   localparam logic [CFG_W-1:0]    SCALE_RESET   = CFG_W'(100);
   localparam logic [GLITCH_W-1:0] GLITCH_MAX    = GLITCH_W'(31);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIVISOR = CSR_IDX_W'(1);

   // Per-tick flags from the readout sequencer
   typedef struct packed {
      logic sck_level;
      logic sample_valid;
      logic timed_out;
   } lcar_tick_type;

   // Averaging / divide unit status towards the top level
   typedef struct packed {
      logic busy;
      logic calc_start;
      logic weight_valid;
      logic tare_done;
   } lcar_avg_status_type;

endpackage

// File: rtl/lcar_chan_if.sv
`timescale 1ns / 1ps

interface lcar_req_if;
   logic valid;
   logic ready;
   logic dout_level;
   logic tare_request;

   modport source (output valid, output dout_level, output tare_request, input ready);
   modport sink   (input valid, input dout_level, input tare_request, output ready);
endinterface

interface lcar_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                sck_level;
   logic                                sample_valid;
   logic [lcar_pkg::RAW_W-1:0]          raw_sample;
   logic [lcar_pkg::GLITCH_W-1:0]       glitch_count;
   logic                                timed_out;
   logic                                weight_valid;
   logic signed [lcar_pkg::WEIGHT_W-1:0] weight_value;
   logic                                tare_done;

   modport source (output valid, output sck_level, output sample_valid, output raw_sample,
                   output glitch_count, output timed_out, output weight_valid,
                   output weight_value, output tare_done, input ready);
   modport sink   (input valid, input sck_level, input sample_valid, input raw_sample,
                   input glitch_count, input timed_out, input weight_valid,
                   input weight_value, input tare_done, output ready);
endinterface

interface lcar_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lcar_pkg::CSR_IDX_W-1:0]  index;
   logic [lcar_pkg::CFG_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/load_cell_adc_reader_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// req_chan in   valid / ready  dout_level, tare_request (one tick per transaction)
// rsp_chan out  valid / ready  sck_level, sample_valid, raw_sample, glitch_count,
//                              timed_out, weight_valid, weight_value, tare_done
// csr_chan in   valid / ready  index, data (0 timeout_ticks, 1 scale_divisor)
//
// Each tick's result lands in the output register, and the next tick can be
// taken in the following cycle, provided that result leaves then. A tick that
// closes a run holds req ready low while the bit-serial divider forms the tare
// level (tare run) or the mean and then the weight (measurement run); DW, the
// divider's dividend width, is 34 at default settings. Synchronous active-high
// reset; a tare run starts straight after reset. A result left waiting on rsp
// ready blocks the next tick; the single output register is freed in the cycle
// it is taken.
module load_cell_adc_reader_top #(
   parameter int SAMPLE_BITS     = lcar_pkg::SAMPLE_BITS_DEF,
   parameter int TARE_SAMPLES    = lcar_pkg::TARE_SAMPLES_DEF,
   parameter int MEASURE_SAMPLES = lcar_pkg::MEASURE_SAMPLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lcar_req_if.sink     req_chan,
   lcar_rsp_if.source   rsp_chan,
   lcar_csr_if.sink     csr_chan
);

   localparam int RAW_EXT_W = (SAMPLE_BITS > lcar_pkg::RAW_W) ? SAMPLE_BITS : lcar_pkg::RAW_W;

   // configuration registers
   logic [lcar_pkg::CFG_W-1:0] timeout_ff, timeout_in;
   logic [lcar_pkg::CFG_W-1:0] scale_ff, scale_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_sck_ff, rsp_sck_in;
   logic                          rsp_sample_valid_ff, rsp_sample_valid_in;
   logic [lcar_pkg::RAW_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic [lcar_pkg::GLITCH_W-1:0] rsp_glitch_ff, rsp_glitch_in;
   logic                          rsp_timed_out_ff, rsp_timed_out_in;
   logic                          rsp_weight_valid_ff, rsp_weight_valid_in;
   logic                          rsp_tare_done_ff, rsp_tare_done_in;

   logic                            accept;
   lcar_pkg::lcar_tick_type         tick;
   logic [SAMPLE_BITS-1:0]          raw;
   logic [RAW_EXT_W-1:0]            raw_ext;
   logic [lcar_pkg::GLITCH_W-1:0]   glitches;
   lcar_pkg::lcar_avg_status_type   avg_status;
   logic signed [lcar_pkg::WEIGHT_W-1:0] weight_value;

   // ---------------------------------------------------------------------
   // Handshakes: a tick is taken when no divide is running and the output
   // register is free or being emptied in this cycle.
   // ---------------------------------------------------------------------
   assign req_chan.ready = !avg_status.busy && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      scale_in   = scale_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            lcar_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_chan.data;
            lcar_pkg::CSR_SCALE_DIVISOR: scale_in   = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // SCK / DOUT sequencer with the serial shift register
   // ---------------------------------------------------------------------
   lcar_readout #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_readout (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .dout_level    (req_chan.dout_level),
      .timeout_ticks (timeout_ff),
      .tick          (tick),
      .raw           (raw),
      .glitches      (glitches)
   );

   // ---------------------------------------------------------------------
   // Run accumulation, tare level and weight division
   // ---------------------------------------------------------------------
   lcar_avg #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TARE_SAMPLES    (TARE_SAMPLES),
      .MEASURE_SAMPLES (MEASURE_SAMPLES)
   ) u_avg (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .tare_request  (req_chan.tare_request),
      .sample_valid  (tick.sample_valid),
      .raw           (raw),
      .scale_divisor (scale_ff),
      .status        (avg_status),
      .weight_value  (weight_value)
   );

   assign raw_ext = RAW_EXT_W'(raw);

   // ---------------------------------------------------------------------
   // Output register. Ticks that finish a run are held back (valid low)
   // until the divider has produced the tare level or the weight.
   // raw_sample and glitch_count hold the last conversion between samples.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_sck_in          = rsp_sck_ff;
      rsp_sample_valid_in = rsp_sample_valid_ff;
      rsp_raw_in          = rsp_raw_ff;
      rsp_glitch_in       = rsp_glitch_ff;
      rsp_timed_out_in    = rsp_timed_out_ff;
      rsp_weight_valid_in = rsp_weight_valid_ff;
      rsp_tare_done_in    = rsp_tare_done_ff;
      if (accept) begin
         rsp_valid_in        = !avg_status.calc_start;
         rsp_sck_in          = tick.sck_level;
         rsp_sample_valid_in = tick.sample_valid;
         rsp_timed_out_in    = tick.timed_out;
         rsp_weight_valid_in = 1'b0;
         rsp_tare_done_in    = 1'b0;
         if (tick.sample_valid) begin
            rsp_raw_in    = raw_ext[lcar_pkg::RAW_W-1:0];
            rsp_glitch_in = glitches;
         end
      end else if (avg_status.weight_valid || avg_status.tare_done) begin
         rsp_valid_in        = 1'b1;
         rsp_weight_valid_in = avg_status.weight_valid;
         rsp_tare_done_in    = avg_status.tare_done;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff          <= lcar_pkg::TIMEOUT_RESET;
         scale_ff            <= lcar_pkg::SCALE_RESET;
         rsp_valid_ff        <= 1'b0;
         rsp_raw_ff          <= '0;
         rsp_glitch_ff       <= '0;
         rsp_weight_valid_ff <= 1'b0;
         rsp_tare_done_ff    <= 1'b0;
      end else begin
         timeout_ff          <= timeout_in;
         scale_ff            <= scale_in;
         rsp_valid_ff        <= rsp_valid_in;
         rsp_raw_ff          <= rsp_raw_in;
         rsp_glitch_ff       <= rsp_glitch_in;
         rsp_weight_valid_ff <= rsp_weight_valid_in;
         rsp_tare_done_ff    <= rsp_tare_done_in;
      end
      rsp_sck_ff          <= rsp_sck_in;
      rsp_sample_valid_ff <= rsp_sample_valid_in;
      rsp_timed_out_ff    <= rsp_timed_out_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sck_level    = rsp_sck_ff;
   assign rsp_chan.sample_valid = rsp_sample_valid_ff;
   assign rsp_chan.raw_sample   = rsp_raw_ff;
   assign rsp_chan.glitch_count = rsp_glitch_ff;
   assign rsp_chan.timed_out    = rsp_timed_out_ff;
   assign rsp_chan.weight_valid = rsp_weight_valid_ff;
   assign rsp_chan.weight_value = weight_value;
   assign rsp_chan.tare_done    = rsp_tare_done_ff;

endmodule

// File: rtl/lcar_readout.sv
`timescale 1ns / 1ps

module lcar_readout #(
   parameter int SAMPLE_BITS = lcar_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          dout_level,
   input  logic [lcar_pkg::CFG_W-1:0]    timeout_ticks,
   output lcar_pkg::lcar_tick_type       tick,
   output logic [SAMPLE_BITS-1:0]        raw,
   output logic [lcar_pkg::GLITCH_W-1:0] glitches
);

   localparam int BIT_W = $clog2(SAMPLE_BITS);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [5:0] {
      PH_WAIT   = 6'b000001,
      PH_HIGH   = 6'b000010,
      PH_LOW1   = 6'b000100,
      PH_LOW2   = 6'b001000,
      PH_EXTRA  = 6'b010000,
      PH_FINISH = 6'b100000
   } lcar_phase_type;

   lcar_phase_type                phase_ff, phase_in;
   logic [BIT_W-1:0]              bit_ff, bit_in;
   logic [SAMPLE_BITS-1:0]        shift_ff, shift_in;
   logic [lcar_pkg::CFG_W-1:0]    wait_ff, wait_in;
   logic [lcar_pkg::GLITCH_W-1:0] glitch_ff, glitch_in;
   logic                          mismatch_ff, mismatch_in;

   logic [lcar_pkg::CFG_W-1:0]    wait_inc;
   logic [lcar_pkg::CFG_W-1:0]    wait_lim;

   assign wait_inc = wait_ff + lcar_pkg::CFG_W'(1);
   assign wait_lim = (timeout_ticks == '0) ? lcar_pkg::CFG_W'(1) : timeout_ticks;

   always_comb begin
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      wait_in     = wait_ff;
      glitch_in   = glitch_ff;
      mismatch_in = mismatch_ff;
      tick        = '0;
      case (phase_ff)
         PH_WAIT: begin
            if (!dout_level) begin
               wait_in   = '0;
               bit_in    = '0;
               shift_in  = '0;
               glitch_in = '0;
               phase_in  = PH_HIGH;
            end else if (wait_inc >= wait_lim) begin
               tick.timed_out = 1'b1;
               wait_in        = '0;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_HIGH: begin
            tick.sck_level = 1'b1;
            shift_in       = {shift_ff[SAMPLE_BITS-2:0], dout_level};
            phase_in       = PH_LOW1;
         end
         PH_LOW1: begin
            mismatch_in = dout_level != shift_ff[0];
            phase_in    = PH_LOW2;
         end
         PH_LOW2: begin
            if ((mismatch_ff || dout_level != shift_ff[0]) && glitch_ff != lcar_pkg::GLITCH_MAX)
               glitch_in = glitch_ff + lcar_pkg::GLITCH_W'(1);
            mismatch_in = 1'b0;
            bit_in      = bit_ff + BIT_W'(1);
            phase_in    = (bit_ff == BIT_W'(SAMPLE_BITS - 1)) ? PH_EXTRA : PH_HIGH;
         end
         PH_EXTRA: begin
            // gain 128 pulse
            tick.sck_level = 1'b1;
            phase_in       = PH_FINISH;
         end
         PH_FINISH: begin
            tick.sample_valid = 1'b1;
            phase_in          = PH_WAIT;
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   assign raw      = shift_ff ^ SAMPLE_TOP;
   assign glitches = glitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         bit_ff      <= '0;
         shift_ff    <= '0;
         wait_ff     <= '0;
         glitch_ff   <= '0;
         mismatch_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         wait_ff     <= wait_in;
         glitch_ff   <= glitch_in;
         mismatch_ff <= mismatch_in;
      end
   end

endmodule

// File: rtl/lcar_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lcar_div #(
   parameter int DIVIDEND_W = 34,
   parameter int DIVISOR_W  = lcar_pkg::CFG_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   assign trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = !trial_sub[DIVISOR_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/lcar_avg.sv
`timescale 1ns / 1ps

module lcar_avg #(
   parameter int SAMPLE_BITS     = lcar_pkg::SAMPLE_BITS_DEF,
   parameter int TARE_SAMPLES    = lcar_pkg::TARE_SAMPLES_DEF,
   parameter int MEASURE_SAMPLES = lcar_pkg::MEASURE_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 tare_request,
   input  logic                                 sample_valid,
   input  logic [SAMPLE_BITS-1:0]               raw,
   input  logic [lcar_pkg::CFG_W-1:0]           scale_divisor,
   output lcar_pkg::lcar_avg_status_type        status,
   output logic signed [lcar_pkg::WEIGHT_W-1:0] weight_value
);

   localparam int MAXN   = (TARE_SAMPLES > MEASURE_SAMPLES) ? TARE_SAMPLES : MEASURE_SAMPLES;
   localparam int CNT_W  = $clog2(MAXN + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAXN);
   localparam int MEAN_W = SAMPLE_BITS + lcar_pkg::MEAN_FRAC;
   localparam int DIFF_W = MEAN_W + 1;
   localparam int MAG_W  = MEAN_W + lcar_pkg::WEIGHT_SHIFT;
   localparam int SUMX_W = SUM_W + lcar_pkg::MEAN_FRAC;
   localparam int DW     = (SUMX_W > MAG_W) ? SUMX_W : MAG_W;
   localparam int SAT_W  = (DW > 34) ? DW : 34;
   localparam int WW     = lcar_pkg::WEIGHT_W;

   localparam logic [SAT_W-1:0] POS_LIMIT = SAT_W'(64'h0_FFFF_FFFF);
   localparam logic [SAT_W-1:0] NEG_LIMIT = SAT_W'(64'h1_0000_0000);
   localparam logic [WW-1:0]    W_MAX     = WW'(64'h0_FFFF_FFFF);
   localparam logic [WW-1:0]    W_MIN     = WW'(64'h1_0000_0000);

   typedef enum logic [3:0] {
      CALC_IDLE   = 4'b0001,
      CALC_MEAN   = 4'b0010,
      CALC_DIFF   = 4'b0100,
      CALC_WEIGHT = 4'b1000
   } lcar_calc_type;

   lcar_calc_type             state_ff, state_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [MEAN_W-1:0]         zero_ff, zero_in;
   logic                      tare_active_ff, tare_active_in;
   logic                      tare_mode_ff, tare_mode_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [WW-1:0]      weight_ff, weight_in;

   logic [SUM_W-1:0]          base_sum, new_sum;
   logic [CNT_W-1:0]          base_cnt, new_cnt;
   logic                      act, tare_full, meas_full, calc_start;
   logic [DIFF_W-1:0]         diff_abs;
   logic [DW-1:0]             mean_dividend, weight_dividend;
   logic [lcar_pkg::CFG_W-1:0] mean_divisor, weight_divisor;
   logic                      div_start, div_done;
   logic [DW-1:0]             div_dividend, div_quotient;
   logic [lcar_pkg::CFG_W-1:0] div_divisor;
   logic [MEAN_W-1:0]         mean;
   logic [SAT_W-1:0]          qx;
   logic [WW-1:0]             weight_sat;

   // a tare request clears the run before this tick's conversion is added
   assign base_sum  = tare_request ? '0 : sum_ff;
   assign base_cnt  = tare_request ? '0 : cnt_ff;
   assign act       = tare_request | tare_active_ff;
   assign new_sum   = base_sum + SUM_W'(raw);
   assign new_cnt   = base_cnt + CNT_W'(1);
   assign tare_full = act && (new_cnt >= CNT_W'(TARE_SAMPLES));
   assign meas_full = !act && (new_cnt >= CNT_W'(MEASURE_SAMPLES));
   assign calc_start = accept && sample_valid && (tare_full || meas_full);

   assign mean_dividend = DW'({new_sum, {lcar_pkg::MEAN_FRAC{1'b0}}});
   assign mean_divisor  = tare_full ? lcar_pkg::CFG_W'(TARE_SAMPLES)
                                    : lcar_pkg::CFG_W'(MEASURE_SAMPLES);

   assign diff_abs        = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
   assign weight_dividend = DW'({diff_abs[DIFF_W-2:0], {lcar_pkg::WEIGHT_SHIFT{1'b0}}});
   assign weight_divisor  = (scale_divisor == '0) ? lcar_pkg::CFG_W'(1) : scale_divisor;

   assign div_dividend = (state_ff == CALC_DIFF) ? weight_dividend : mean_dividend;
   assign div_divisor  = (state_ff == CALC_DIFF) ? weight_divisor : mean_divisor;

   assign mean = div_quotient[MEAN_W-1:0];

   // truncated toward zero, then clamped to the 33-bit range
   assign qx = SAT_W'(div_quotient);
   always_comb begin
      if (diff_ff[DIFF_W-1])
         weight_sat = (qx > NEG_LIMIT) ? W_MIN : WW'(-qx[WW-1:0]);
      else
         weight_sat = (qx > POS_LIMIT) ? W_MAX : qx[WW-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      zero_in        = zero_ff;
      tare_active_in = tare_active_ff;
      tare_mode_in   = tare_mode_ff;
      diff_in        = diff_ff;
      weight_in      = weight_ff;
      div_start      = 1'b0;
      status         = '0;

      if (accept) begin
         sum_in         = base_sum;
         cnt_in         = base_cnt;
         tare_active_in = act;
         if (sample_valid) begin
            if (tare_full || meas_full) begin
               sum_in       = '0;
               cnt_in       = '0;
               div_start    = 1'b1;
               state_in     = CALC_MEAN;
               tare_mode_in = tare_full;
               if (tare_full)
                  tare_active_in = 1'b0;
            end else begin
               sum_in = new_sum;
               cnt_in = new_cnt;
            end
         end
      end

      case (state_ff)
         CALC_IDLE: begin
         end
         CALC_MEAN: begin
            if (div_done) begin
               if (tare_mode_ff) begin
                  zero_in          = mean;
                  status.tare_done = 1'b1;
                  state_in         = CALC_IDLE;
               end else begin
                  diff_in  = $signed({1'b0, mean}) - $signed({1'b0, zero_ff});
                  state_in = CALC_DIFF;
               end
            end
         end
         CALC_DIFF: begin
            div_start = 1'b1;
            state_in  = CALC_WEIGHT;
         end
         CALC_WEIGHT: begin
            if (div_done) begin
               weight_in           = weight_sat;
               status.weight_valid = 1'b1;
               state_in            = CALC_IDLE;
            end
         end
         default: begin
            state_in = CALC_IDLE;
         end
      endcase

      status.busy       = state_ff != CALC_IDLE;
      status.calc_start = calc_start;
   end

   lcar_div #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (lcar_pkg::CFG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CALC_IDLE;
         sum_ff         <= '0;
         cnt_ff         <= '0;
         zero_ff        <= '0;
         tare_active_ff <= 1'b1;
         tare_mode_ff   <= 1'b0;
         weight_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         sum_ff         <= sum_in;
         cnt_ff         <= cnt_in;
         zero_ff        <= zero_in;
         tare_active_ff <= tare_active_in;
         tare_mode_ff   <= tare_mode_in;
         weight_ff      <= weight_in;
      end
      diff_ff <= diff_in;
   end

   assign weight_value = weight_ff;

endmodule
